/* sv/rlp_pkg.sv */
// ----------------------------------------------------------------------------
// Route line parser package
// Beat types, byte classes, error codes and character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rlp_pkg;

  localparam int unsigned TimeW = 31;
  localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [2:0] CLS_SKIP   = 3'd0;
  localparam logic [2:0] CLS_NAME   = 3'd1;
  localparam logic [2:0] CLS_ST_CH  = 3'd2;
  localparam logic [2:0] CLS_OPEN_Q = 3'd3;
  localparam logic [2:0] CLS_CLOSE_Q = 3'd4;
  localparam logic [2:0] CLS_DIGIT  = 3'd5;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_NO_COLON    = 4'd1;
  localparam logic [3:0] ERR_EMPTY_NAME  = 4'd2;
  localparam logic [3:0] ERR_NO_QUOTE    = 4'd3;
  localparam logic [3:0] ERR_UNCLOSED    = 4'd4;
  localparam logic [3:0] ERR_EMPTY_ST    = 4'd5;
  localparam logic [3:0] ERR_NO_TIME     = 4'd6;
  localparam logic [3:0] ERR_TOO_LARGE   = 4'd7;
  localparam logic [3:0] ERR_ZERO_TIME   = 4'd8;
  localparam logic [3:0] ERR_FEW_ST      = 4'd9;
  localparam logic [3:0] ERR_ENDS_ON_TM  = 4'd10;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]       byte_class;
    logic             is_blank;
    logic             time_valid;
    logic [TimeW-1:0] time_value;
    logic             line_done;
    logic             line_ok;
    logic [3:0]       error_code;
  } out_beat_t;

  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } step_req_t;

endpackage

`default_nettype wire

/* sv/rlp_core.sv */
// ----------------------------------------------------------------------------
// Route line parser core
// Holds the line state and computes the result beat for one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rlp_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rlp_pkg::step_req_t req,
  output rlp_pkg::out_beat_t      res
);

  typedef enum logic [2:0] {
    PH_NAME,
    PH_SEEK_ST,
    PH_IN_ST,
    PH_SEEK_TM,
    PH_IN_TM,
    PH_FAIL
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [rlp_pkg::TimeW-1:0]  acc_r, acc_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic                       name_r, name_nxt;
  logic                       stch_r, stch_nxt;
  logic [3:0]                 err_r, err_nxt;

  logic [7:0]                 b;
  logic                       last;
  logic                       blank;
  logic                       digit;
  logic [rlp_pkg::TimeW-1:0]  acc_src;
  logic [rlp_pkg::TimeW+3:0]  mac;
  logic                       ovf;
  logic [2:0]                 cls;
  logic                       tv;
  logic [rlp_pkg::TimeW-1:0]  tval;

  assign b     = req.beat.in_byte;
  assign last  = req.beat.line_end;
  assign blank = (b == rlp_pkg::CH_SPACE) || (b inside {[rlp_pkg::CH_TAB:rlp_pkg::CH_CR]});
  assign digit = b inside {[rlp_pkg::CH_ZERO:rlp_pkg::CH_NINE]};

  // A new time starts from zero when the first digit arrives.
  assign acc_src = (phase_r == PH_SEEK_TM) ? '0 : acc_r;
  assign mac = ({4'b0, acc_src} << 3) + ({4'b0, acc_src} << 1)
             + {{(rlp_pkg::TimeW){1'b0}}, b[3:0]};
  assign ovf = mac > {4'b0, rlp_pkg::TIME_MAX};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    name_nxt  = name_r;
    stch_nxt  = stch_r;
    err_nxt   = err_r;
    cls       = rlp_pkg::CLS_SKIP;
    tv        = 1'b0;
    tval      = '0;

    case (phase_r)
      PH_NAME: begin
        if (b == rlp_pkg::CH_COLON) begin
          if (!name_r) begin
            err_nxt   = rlp_pkg::ERR_EMPTY_NAME;
            phase_nxt = PH_FAIL;
          end else begin
            phase_nxt = PH_SEEK_ST;
          end
        end else begin
          cls = rlp_pkg::CLS_NAME;
          if (!blank) begin
            name_nxt = 1'b1;
          end
        end
      end
      PH_SEEK_ST: begin
        if (!blank) begin
          if (b == rlp_pkg::CH_QUOTE) begin
            stch_nxt  = 1'b0;
            phase_nxt = PH_IN_ST;
            cls       = rlp_pkg::CLS_OPEN_Q;
          end else begin
            err_nxt   = rlp_pkg::ERR_NO_QUOTE;
            phase_nxt = PH_FAIL;
          end
        end
      end
      PH_IN_ST: begin
        if (b == rlp_pkg::CH_QUOTE) begin
          cls = rlp_pkg::CLS_CLOSE_Q;
          if (!stch_r) begin
            err_nxt   = rlp_pkg::ERR_EMPTY_ST;
            phase_nxt = PH_FAIL;
          end else begin
            if (cnt_r < 2'd2) begin
              cnt_nxt = cnt_r + 2'd1;
            end
            phase_nxt = PH_SEEK_TM;
          end
        end else begin
          cls      = rlp_pkg::CLS_ST_CH;
          stch_nxt = 1'b1;
        end
      end
      PH_SEEK_TM, PH_IN_TM: begin
        if (digit) begin
          if (phase_r == PH_SEEK_TM) begin
            acc_nxt = '0;
          end
          if (ovf) begin
            err_nxt   = rlp_pkg::ERR_TOO_LARGE;
            phase_nxt = PH_FAIL;
          end else begin
            acc_nxt   = mac[rlp_pkg::TimeW-1:0];
            phase_nxt = PH_IN_TM;
            cls       = rlp_pkg::CLS_DIGIT;
          end
        end else if (phase_r == PH_SEEK_TM) begin
          if (!blank) begin
            err_nxt   = rlp_pkg::ERR_NO_TIME;
            phase_nxt = PH_FAIL;
          end
        end else if (acc_r == '0) begin
          err_nxt   = rlp_pkg::ERR_ZERO_TIME;
          phase_nxt = PH_FAIL;
        end else begin
          tv        = 1'b1;
          tval      = acc_r;
          acc_nxt   = '0;
          phase_nxt = PH_SEEK_ST;
          if (!blank) begin
            if (b == rlp_pkg::CH_QUOTE) begin
              stch_nxt  = 1'b0;
              phase_nxt = PH_IN_ST;
              cls       = rlp_pkg::CLS_OPEN_Q;
            end else begin
              err_nxt   = rlp_pkg::ERR_NO_QUOTE;
              phase_nxt = PH_FAIL;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (last) begin
      case (phase_nxt)
        PH_NAME: begin
          err_nxt = rlp_pkg::ERR_NO_COLON;
        end
        PH_SEEK_ST: begin
          err_nxt = (cnt_nxt < 2'd2) ? rlp_pkg::ERR_FEW_ST : rlp_pkg::ERR_ENDS_ON_TM;
        end
        PH_IN_ST: begin
          err_nxt = rlp_pkg::ERR_UNCLOSED;
        end
        PH_SEEK_TM: begin
          if (cnt_nxt < 2'd2) begin
            err_nxt = rlp_pkg::ERR_FEW_ST;
          end
        end
        PH_IN_TM: begin
          if (acc_nxt == '0) begin
            err_nxt = rlp_pkg::ERR_ZERO_TIME;
          end else begin
            tv      = 1'b1;
            tval    = acc_nxt;
            err_nxt = (cnt_nxt < 2'd2) ? rlp_pkg::ERR_FEW_ST : rlp_pkg::ERR_ENDS_ON_TM;
          end
        end
        default: begin
        end
      endcase
    end

    res.byte_class = cls;
    res.is_blank   = blank;
    res.time_valid = tv;
    res.time_value = tval;
    res.line_done  = last;
    res.line_ok    = last && (err_nxt == rlp_pkg::ERR_NONE);
    res.error_code = err_nxt;
  end

  // The last byte of a line returns all state to its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NAME;
      acc_r   <= '0;
      cnt_r   <= 2'd0;
      name_r  <= 1'b0;
      stch_r  <= 1'b0;
      err_r   <= rlp_pkg::ERR_NONE;
    end else if (req.valid) begin
      if (last) begin
        phase_r <= PH_NAME;
        acc_r   <= '0;
        cnt_r   <= 2'd0;
        name_r  <= 1'b0;
        stch_r  <= 1'b0;
        err_r   <= rlp_pkg::ERR_NONE;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
        name_r  <= name_nxt;
        stch_r  <= stch_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/route_line_parser_top.sv */
// ----------------------------------------------------------------------------
// Route line parser top level
// Input register, parse core and result register with valid/ready channels.
// ----------------------------------------------------------------------------
// A beat accepted into the input register is parsed when the core steps, which loads its result beat.
// Throughput: one beat per cycle while out_ready drains the result register; the core result is combinational.
// The input register takes a new beat while the result register still waits only if it is empty.
// Reset (rst_n low, synchronous) empties both registers and starts a new line.
`default_nettype none

module route_line_parser_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rlp_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rlp_pkg::out_beat_t     out_data
);

  logic               in_valid_r;
  rlp_pkg::in_beat_t  in_beat_r;
  logic               out_valid_r;
  rlp_pkg::out_beat_t out_beat_r;
  logic               step;
  rlp_pkg::step_req_t req;
  rlp_pkg::out_beat_t res;

  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;
  assign req      = '{valid: step, beat: in_beat_r};

  rlp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_beat_r <= in_data;
    end
    if (step) begin
      out_beat_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

  a_ok_only_on_done : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.line_ok |-> out_data.line_done
                                      && out_data.error_code == rlp_pkg::ERR_NONE)
    else $error("line_ok without a clean line end");

  a_time_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.time_valid |-> out_data.time_value != '0)
    else $error("completed time of zero");

  a_stall_holds_input : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_result_after_step : assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid)
    else $error("processed beat produced no result");

endmodule

`default_nettype wire
